[hdl/bresenham_line_colour_raster_macros.svh]
// assertion macros for the line raster block
`ifndef BRESENHAM_LINE_COLOUR_RASTER_MACROS_SVH
`define BRESENHAM_LINE_COLOUR_RASTER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hdl/blcr_pkg.sv]
// shared constants for the line raster block
package blcr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int FRAC_BITS   = 8;
  localparam int CHANNELS    = 4;
  localparam int CHAN_BITS   = 8;
  localparam int COLOUR_BITS = CHANNELS * CHAN_BITS;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

endpackage

[hdl/blcr_intf.sv]
// command and pixel channel interfaces
interface blcr_cmd_if #(
  parameter int COORD_BITS = blcr_pkg::COORD_BITS
) ();
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [COORD_BITS-1:0]            start_x;
  logic [COORD_BITS-1:0]            start_y;
  logic [COORD_BITS-1:0]            end_x;
  logic [COORD_BITS-1:0]            end_y;
  logic [blcr_pkg::COLOUR_BITS-1:0] start_colour;
  logic [blcr_pkg::COLOUR_BITS-1:0] end_colour;

  modport source (
    output valid, mode, start_x, start_y, end_x, end_y, start_colour, end_colour,
    input  ready
  );
  modport sink (
    input  valid, mode, start_x, start_y, end_x, end_y, start_colour, end_colour,
    output ready
  );
endinterface

interface blcr_pix_if #(
  parameter int COORD_BITS = blcr_pkg::COORD_BITS
) ();
  logic                             valid;
  logic                             ready;
  logic [COORD_BITS-1:0]            pixel_x;
  logic [COORD_BITS-1:0]            pixel_y;
  logic [blcr_pkg::COLOUR_BITS-1:0] pixel_colour;
  logic                             last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_colour, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_colour, last,
    output ready
  );
endinterface

[hdl/blcr_div.sv]
// restoring divider, one quotient bit per cycle
module blcr_div #(
  parameter int NUM_BITS = blcr_pkg::CHAN_BITS + blcr_pkg::FRAC_BITS,
  parameter int DEN_BITS = blcr_pkg::COORD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quo
);

  localparam int CNT_W = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [NUM_BITS-1:0] num_sh;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS:0]   rem_sub;
  logic                qbit;

  always_comb begin
    rem_sh  = {rem, num_sh[NUM_BITS-1]};
    qbit    = (rem_sh >= {1'b0, den});
    rem_sub = qbit ? (rem_sh - {1'b0, den}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        num_sh <= num;
        rem    <= '0;
        cnt    <= '0;
      end else if (busy) begin
        rem    <= rem_sub[DEN_BITS-1:0];
        num_sh <= num_sh << 1;
        quo    <= {quo[NUM_BITS-2:0], qbit};
        cnt    <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/bresenham_line_colour_raster.sv]
// line rasterizer with per-channel colour interpolation
//
//   channel  dir  beat carries
//   cmd      in   mode, start_x, start_y, end_x, end_y, start_colour, end_colour
//   pix      out  pixel_x, pixel_y, pixel_colour, last
//
// step beat: pixel appears in the output register the cycle after the beat is taken
// start beat: each channel in turn passes S_LOAD and S_WAIT, one quotient bit per cycle
//   through the shared divider, channel after channel
// cmd is taken in idle whenever the output register is empty or being drained
// synchronous reset clears position, spans, counters and accumulators
module bresenham_line_colour_raster #(
  parameter int COORD_BITS = blcr_pkg::COORD_BITS,
  parameter int FRAC_BITS  = blcr_pkg::FRAC_BITS
) (
  input logic         clk,
  input logic         rst,
  blcr_cmd_if.sink    cmd,
  blcr_pix_if.source  pix
);

`include "bresenham_line_colour_raster_macros.svh"

  localparam int CH_BITS  = blcr_pkg::CHAN_BITS;
  localparam int NCH      = blcr_pkg::CHANNELS;
  localparam int COL_BITS = blcr_pkg::COLOUR_BITS;
  localparam int ACC_W    = CH_BITS + FRAC_BITS;
  localparam int DELTA_W  = ACC_W + 1;
  localparam int ERR_W    = COORD_BITS + 3;
  localparam int CH_IDX_W = $clog2(NCH);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_WAIT} state_t;

  state_t                     state;
  logic [COORD_BITS-1:0]      cur_x;
  logic [COORD_BITS-1:0]      cur_y;
  logic                       y_is_major;
  logic                       major_step_neg;
  logic                       minor_step_neg;
  logic signed [ERR_W-1:0]    err_acc;
  logic [COORD_BITS-1:0]      major_span;
  logic [COORD_BITS-1:0]      minor_span;
  logic [COORD_BITS-1:0]      pixels_left;
  logic [ACC_W-1:0]           colour_acc [NCH];
  logic signed [DELTA_W-1:0]  colour_delta [NCH];
  logic [COL_BITS-1:0]        c0;
  logic [COL_BITS-1:0]        c1;
  logic [CH_IDX_W-1:0]        ch;

  logic                       out_valid;
  logic [COORD_BITS-1:0]      out_x;
  logic [COORD_BITS-1:0]      out_y;
  logic [COL_BITS-1:0]        out_colour;
  logic                       out_last;

  logic                       cmd_fire;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      adx;
  logic [COORD_BITS-1:0]      ady;
  logic                       y_major_in;

  logic [CH_BITS-1:0]         ch_a;
  logic [CH_BITS-1:0]         ch_b;
  logic [CH_BITS:0]           ch_diff;
  logic                       ch_neg;
  logic [CH_BITS-1:0]         ch_mag;
  logic [ACC_W-1:0]           div_num;
  logic                       div_start;
  logic                       div_done;
  logic [ACC_W-1:0]           div_quo;
  logic signed [DELTA_W-1:0]  div_delta;

  logic signed [ERR_W-1:0]    err_add;
  logic signed [ERR_W-1:0]    major_term;
  logic                       minor_hit;
  logic signed [ERR_W-1:0]    err_next;
  logic [COL_BITS-1:0]        colour_now;

  function automatic logic [COORD_BITS-1:0] step_coord(
    input logic [COORD_BITS-1:0] v,
    input logic                  neg
  );
    return neg ? (v - COORD_BITS'(1)) : (v + COORD_BITS'(1));
  endfunction

  assign cmd.ready = (state == S_IDLE) && (!out_valid || pix.ready);
  assign cmd_fire  = cmd.valid && cmd.ready;

  assign pix.valid        = out_valid;
  assign pix.pixel_x      = out_x;
  assign pix.pixel_y      = out_y;
  assign pix.pixel_colour = out_colour;
  assign pix.last         = out_last;

  // span and direction decode of a start beat
  always_comb begin
    dx  = $signed({1'b0, cmd.end_x}) - $signed({1'b0, cmd.start_x});
    dy  = $signed({1'b0, cmd.end_y}) - $signed({1'b0, cmd.start_y});
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    y_major_in = (ady > adx);
  end

  // channel difference feeding the divider
  always_comb begin
    ch_a    = c0[ch*CH_BITS +: CH_BITS];
    ch_b    = c1[ch*CH_BITS +: CH_BITS];
    ch_diff = {1'b0, ch_b} - {1'b0, ch_a};
    ch_neg  = ch_diff[CH_BITS];
    ch_mag  = ch_neg ? CH_BITS'(-ch_diff) : ch_diff[CH_BITS-1:0];
    div_num = {ch_mag, {FRAC_BITS{1'b0}}};
    div_delta = ch_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  end

  // error term for the minor axis
  always_comb begin
    err_add    = err_acc + $signed(ERR_W'({minor_span, 1'b0}));
    major_term = $signed(ERR_W'(major_span));
    minor_hit  = (err_add > major_term);
    err_next   = minor_hit ? (err_add - (major_term <<< 1)) : err_add;
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      colour_now[k*CH_BITS +: CH_BITS] = colour_acc[k][ACC_W-1:FRAC_BITS];
    end
  end

  blcr_div #(
    .NUM_BITS (ACC_W),
    .DEN_BITS (COORD_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (major_span),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cur_x          <= '0;
      cur_y          <= '0;
      y_is_major     <= 1'b0;
      major_step_neg <= 1'b0;
      minor_step_neg <= 1'b0;
      err_acc        <= '0;
      major_span     <= '0;
      minor_span     <= '0;
      pixels_left    <= '0;
      ch             <= '0;
      div_start      <= 1'b0;
      out_valid      <= 1'b0;
      for (int k = 0; k < NCH; k++) begin
        colour_acc[k]   <= '0;
        colour_delta[k] <= '0;
      end
    end else begin
      div_start <= 1'b0;
      if (out_valid && pix.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            if (cmd.mode == blcr_pkg::MODE_START) begin
              cur_x      <= cmd.start_x;
              cur_y      <= cmd.start_y;
              y_is_major <= y_major_in;
              if (y_major_in) begin
                major_span     <= ady;
                minor_span     <= adx;
                pixels_left    <= ady;
                major_step_neg <= dy[COORD_BITS];
                minor_step_neg <= dx[COORD_BITS];
              end else begin
                major_span     <= adx;
                minor_span     <= ady;
                pixels_left    <= adx;
                major_step_neg <= dx[COORD_BITS];
                minor_step_neg <= dy[COORD_BITS];
              end
              err_acc <= '0;
              c0      <= cmd.start_colour;
              c1      <= cmd.end_colour;
              for (int k = 0; k < NCH; k++) begin
                colour_acc[k]   <= {cmd.start_colour[k*CH_BITS +: CH_BITS],
                                    {FRAC_BITS{1'b0}}};
                colour_delta[k] <= '0;
              end
              ch <= '0;
              if ((y_major_in ? ady : adx) != '0) begin
                state <= S_LOAD;
              end
            end else if (pixels_left != '0) begin
              out_valid  <= 1'b1;
              out_x      <= cur_x;
              out_y      <= cur_y;
              out_colour <= colour_now;
              out_last   <= (pixels_left == COORD_BITS'(1));
              for (int k = 0; k < NCH; k++) begin
                colour_acc[k] <= colour_acc[k] + colour_delta[k][ACC_W-1:0];
              end
              err_acc <= err_next;
              if (y_is_major) begin
                cur_y <= step_coord(cur_y, major_step_neg);
                if (minor_hit) begin
                  cur_x <= step_coord(cur_x, minor_step_neg);
                end
              end else begin
                cur_x <= step_coord(cur_x, major_step_neg);
                if (minor_hit) begin
                  cur_y <= step_coord(cur_y, minor_step_neg);
                end
              end
              pixels_left <= pixels_left - COORD_BITS'(1);
            end
          end
        end
        S_LOAD: begin
          div_start <= 1'b1;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            colour_delta[ch] <= div_delta;
            if (ch == CH_IDX_W'(NCH - 1)) begin
              state <= S_IDLE;
            end else begin
              ch    <= ch + CH_IDX_W'(1);
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a divider result only lands while the sequencer waits for it
  `ASSERT_IMPL(a_div_done_in_wait, clk, rst, div_done, state == S_WAIT)
  // the last pixel leaves only once the line is used up
  `ASSERT_IMPL(a_last_empties, clk, rst, pix.valid && pix.ready && pix.last,
               pixels_left == '0)
  // a step with nothing left produces no beat
  `ASSERT_NEXT(a_empty_step_silent, clk, rst,
               cmd_fire && cmd.mode == blcr_pkg::MODE_STEP && pixels_left == '0
               && !out_valid, !pix.valid)

endmodule
